// ===== rtl/core/khm_pkg.sv =====
// ----------------------------------------------------------------------------
// khm_pkg
// Shared types, constants and the character code function of the keyword
// hash matcher.
// ----------------------------------------------------------------------------
package khm_pkg;

	// Keyword table geometry.
	localparam int TABLE_DEPTH = 64;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);

	// Key packing.
	localparam int KEY_W  = 60;
	localparam int CODE_W = 6;
	localparam int CNT_W  = 4;
	localparam int CHAR_W = 7;

	localparam logic [CNT_W-1:0] CNT_MAX      = 4'd15;
	localparam logic [CNT_W-1:0] FULL_MAX_LEN = 4'd10;
	localparam logic [CNT_W-1:0] SLICE_MIN    = 4'd2;
	localparam logic [CNT_W-1:0] SLICE_MAX    = 4'd9;

	// Item commands.
	localparam logic [1:0] CMD_KEYWORD = 2'd0;
	localparam logic [1:0] CMD_QUERY   = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// Register file.
	localparam int         ADDR_W         = 3;
	localparam logic       REG_SLICE_RULE = 1'b0;

	typedef struct packed {
		logic [1:0]        command;
		logic [CHAR_W-1:0] char_code;
		logic              word_end;
	} in_item_t;

	typedef struct packed {
		logic             is_keyword;
		logic [KEY_W-1:0] word_key;
		logic             table_overflowed;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_item;
		logic rd_en;
		logic out_load;
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic query_end;
		logic go_search;
		logic rd_last;
		logic out_busy;
	} dp_status_t;

	// Maps an ASCII character to its six-bit code; unlisted characters give zero.
	function automatic logic [CODE_W-1:0] char_to_code(input logic [CHAR_W-1:0] c);
		logic [CODE_W-1:0] code;
		code = '0;
		case (c) inside
			7'h5F:         code = 6'd1;
			[7'h30:7'h39]: code = CODE_W'(c - 7'd46);
			[7'h41:7'h5A]: code = CODE_W'(c - 7'd53);
			[7'h61:7'h7A]: code = CODE_W'(c - 7'd59);
			default:       code = '0;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/core/khm_ctrl.sv =====
// ----------------------------------------------------------------------------
// khm_ctrl
// Controller of the keyword hash matcher: sequences the table search and
// the hand-off of a result to the output register.
// ----------------------------------------------------------------------------
module khm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  khm_pkg::dp_status_t sts,
	output khm_pkg::dp_ctrl_t   ctrl
);
	import khm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.query_end) begin
					state_d = sts.go_search ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (sts.rd_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall       = (state_q != ST_IDLE);
		ctrl.take_item = (state_q == ST_IDLE) && in_valid;
		ctrl.rd_en     = (state_q == ST_SEARCH);
		ctrl.out_load  = (state_q == ST_DONE) && !sts.out_busy;
	end

endmodule

// ===== rtl/core/khm_datapath.sv =====
// ----------------------------------------------------------------------------
// khm_datapath
// Key packing, keyword table memory, sequential table compare and the
// output register of the keyword hash matcher.
// ----------------------------------------------------------------------------
module khm_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  khm_pkg::in_item_t   in_data,
	input  logic                slice_rule,
	input  khm_pkg::dp_ctrl_t   ctrl,
	output khm_pkg::dp_status_t sts,
	output logic                out_valid,
	input  logic                out_stall,
	output khm_pkg::out_item_t  out_data
);
	import khm_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TBL_CW-1:0] kw_count_q;
	logic              ovf_q;

	logic [KEY_W-1:0]  mem [TABLE_DEPTH];
	logic [KEY_W-1:0]  rdata_s1;
	logic              rvalid_s1;
	logic [TBL_AW-1:0] idx_q;

	logic [KEY_W-1:0]  qkey_q;
	logic              qovf_q;
	logic              hit_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [KEY_W-1:0]  key_nx;
	logic [CNT_W-1:0]  cnt_nx;
	logic [KEY_W-1:0]  full_key;
	logic [KEY_W-1:0]  query_key;
	logic              elig_slice;
	logic              elig_full;
	logic              tbl_full;
	logic              is_char;
	logic              kw_store;

	// The shifted key has six zero bits at the bottom, so the add is a concatenation.
	assign key_nx    = {key_q[KEY_W-CODE_W-1:0], char_to_code(in_data.char_code)};
	assign cnt_nx    = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign full_key  = (cnt_nx > FULL_MAX_LEN) ? '0 : key_nx;
	assign query_key = slice_rule ? key_nx : full_key;

	assign elig_slice = (cnt_nx >= SLICE_MIN) && (cnt_nx <= SLICE_MAX);
	assign elig_full  = (cnt_nx <= FULL_MAX_LEN) && (full_key != '0);
	assign tbl_full   = (kw_count_q == TBL_CW'(TABLE_DEPTH));
	assign is_char    = (in_data.command == CMD_KEYWORD) || (in_data.command == CMD_QUERY);
	assign kw_store   = ctrl.take_item && (in_data.command == CMD_KEYWORD) &&
	                    in_data.word_end && !tbl_full;

	assign sts.query_end = (in_data.command == CMD_QUERY) && in_data.word_end;
	assign sts.go_search = (slice_rule ? elig_slice : elig_full) && (kw_count_q != '0);
	assign sts.rd_last   = ((TBL_CW'(idx_q) + TBL_CW'(1)) == kw_count_q);
	assign sts.out_busy  = out_valid_q && out_stall;

	// Word accumulator, table fill count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			cnt_q      <= '0;
			kw_count_q <= '0;
			ovf_q      <= 1'b0;
		end else if (ctrl.take_item) begin
			if (in_data.command == CMD_CLEAR) begin
				key_q      <= '0;
				cnt_q      <= '0;
				kw_count_q <= '0;
				ovf_q      <= 1'b0;
			end else if (is_char) begin
				if (in_data.word_end) begin
					key_q <= '0;
					cnt_q <= '0;
					if (in_data.command == CMD_KEYWORD) begin
						if (tbl_full) begin
							ovf_q <= 1'b1;
						end else begin
							kw_count_q <= kw_count_q + 1'b1;
						end
					end
				end else begin
					key_q <= key_nx;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	// Keyword table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (kw_store) begin
			mem[kw_count_q[TBL_AW-1:0]] <= full_key;
		end
		if (ctrl.rd_en) begin
			rdata_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= ctrl.rd_en;
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Query snapshot, search index and hit accumulation.
	always_ff @(posedge clk) begin
		if (ctrl.take_item && sts.query_end) begin
			qkey_q <= query_key;
			qovf_q <= ovf_q;
			hit_q  <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (ctrl.rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rvalid_s1 && (rdata_s1 == qkey_q)) begin
				hit_q <= 1'b1;
			end
		end
		if (ctrl.out_load) begin
			out_q.is_keyword       <= hit_q;
			out_q.word_key         <= qkey_q;
			out_q.table_overflowed <= qovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/core/keyword_hash_matcher.sv =====
// ----------------------------------------------------------------------------
// keyword_hash_matcher
// Packs characters into six-bit-per-character keys, stores keyword keys
// in a table and reports whether each finished query word is a keyword.
//
// A character that does not end a query word leaves the input ready. A
// query word end steps the controller through its search, drain and done
// states, or goes straight to the done state when the word cannot match or
// the table is empty; the single read port of the table reads one entry
// per cycle. Throughput: one character per cycle while the input is not
// held; a query end holds the input until its result is loaded.
// Reset: arst_n clears the word, the table count, the overflow flag, the
// slice rule and the output valid flag; table contents are not cleared.
// ----------------------------------------------------------------------------
module keyword_hash_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [khm_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// Input item channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  khm_pkg::in_item_t           in_data,
	// Result item channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output khm_pkg::out_item_t          out_data
);
	import khm_pkg::*;

	logic       slice_rule_q;
	logic       reg_sel;
	dp_ctrl_t   ctrl;
	dp_status_t sts;

	// The register index is the word address; bit 2 of the byte address.
	assign reg_sel = (paddr[2] == REG_SLICE_RULE);
	assign pready  = 1'b1;

	// The slice rule register is written on the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_rule_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_sel) begin
			slice_rule_q <= pwdata[0];
		end
	end

	// Reads of an address beyond the register list return zero.
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = slice_rule_q;
		end
	end

	// The controller holds the input channel while a query searches the table
	// and waits when the previous result has not yet been taken.
	khm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctrl     (ctrl)
	);

	// The datapath packs characters, fills the table and compares the query
	// key against every stored entry, one per cycle.
	khm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_data    (in_data),
		.slice_rule (slice_rule_q),
		.ctrl       (ctrl),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/core/khm_checker.sv =====
// ----------------------------------------------------------------------------
// khm_checker
// Port-level assertions for the keyword hash matcher, bound to the top level.
// ----------------------------------------------------------------------------
module khm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input khm_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input khm_pkg::out_item_t out_data
);
	import khm_pkg::*;

	logic in_take;
	logic query_end;

	assign in_take   = in_valid && !in_stall;
	assign query_end = (in_data.command == CMD_QUERY) && in_data.word_end;

	// A finished query word always holds the input, whether or not it searches the table.
	a_query_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && query_end |=> in_stall)
		else $error("input not held after a query word end");

	// Any other item leaves the block ready for the next character.
	a_char_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !query_end |=> !in_stall)
		else $error("input held after an item that needs no search");

	// A stalled result stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// A result is withdrawn only after it was taken.
	a_out_fall_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result withdrawn without being taken");

endmodule

bind keyword_hash_matcher khm_checker u_khm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
